// ----- src/tdp_pkg.sv -----
`timescale 1ns / 1ps

package tdp_pkg;

  // width of the tested number
  localparam int unsigned WIDTH = 32;

  // bit counter of the serial divider
  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EVAL = 2'd2;

endpackage

// ----- src/trial_division_primality.sv -----
`timescale 1ns / 1ps

// Trial-division primality tester. A transaction is taken when start_i is high
// while busy_o is low; the answer is given on is_prime_o while done_o is high for exactly one cycle,
// and must be captured then, as the block cannot be stalled.
// 0, 1 and every even number, two included, are answered in the cycle after the start.
// Any other number runs through odd trial divisors 3, 5, 7 and onward on a single
// restoring divider that yields one quotient bit per cycle, so each trial
// takes WIDTH divide steps plus one evaluation step, and a number n takes
// about sqrt(n) / 2 trials. busy_o stays high throughout.
module trial_division_primality
  import tdp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] number_i,
  output logic             busy_o,
  output logic             done_o,
  output logic             is_prime_o
);

  logic [1:0]       state_q, state_d;
  logic [WIDTH-1:0] n_q, n_d;
  logic [WIDTH-1:0] d_q, d_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic             prime_q, prime_d;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   diff;
  logic             fits;
  logic             accept;

  assign accept = start_i && (state_q == ST_IDLE);

  // one restoring divide step
  assign trial = {rem_q, quo_q[WIDTH-1]};
  assign diff  = trial - {1'b0, d_q};
  assign fits  = (trial >= {1'b0, d_q});

  // sequencer
  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    d_d     = d_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    prime_d = prime_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          n_d = number_i;
          if ((number_i[WIDTH-1:1] == '0) || !number_i[0]) begin
            // below two, or even: only two itself is prime
            done_d  = 1'b1;
            prime_d = (number_i == WIDTH'(2));
          end else begin
            d_d     = WIDTH'(3);
            rem_d   = '0;
            quo_d   = number_i;
            cnt_d   = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_d = fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
        quo_d = {quo_q[WIDTH-2:0], fits};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(WIDTH - 1)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (d_q > quo_q) begin
          // divisor passed the square root
          done_d  = 1'b1;
          prime_d = 1'b1;
          state_d = ST_IDLE;
        end else if (rem_q == '0) begin
          done_d  = 1'b1;
          prime_d = 1'b0;
          state_d = ST_IDLE;
        end else begin
          d_d     = d_q + WIDTH'(2);
          rem_d   = '0;
          quo_d   = n_q;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    d_q     <= d_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    prime_q <= prime_d;
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign is_prime_o = prime_q;

`ifndef SYNTHESIS
  // a result is only given once the sequencer is back at rest
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while busy");

  // even numbers above two are rejected at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !number_i[0] && (number_i[WIDTH-1:2] != '0))
      |=> (done_o && !is_prime_o))
    else $error("even number not rejected");

  // the remainder stays below the divisor after a full division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (rem_q < d_q))
    else $error("remainder not below divisor");

  // trial divisors are always odd
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> d_q[0])
    else $error("even trial divisor");
`endif

endmodule
